[rtl/core/query_text_normalizer_defines.svh]
// Assertion macros shared by the normalizer RTL
`ifndef QUERY_TEXT_NORMALIZER_DEFINES_SVH
`define QUERY_TEXT_NORMALIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define QTN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define QTN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/qtn_pkg.sv]
// Types, character codes and status codes of the query text normalizer
package qtn_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IN_LONG   = 3'd1;
    localparam logic [2:0] ST_OUT_LONG  = 3'd2;
    localparam logic [2:0] ST_ODD_QUOTE = 3'd3;
    localparam logic [2:0] ST_PAREN     = 3'd4;

    localparam logic [0:0] REG_MAX_LENGTH = 1'b0;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd4096;

    typedef struct packed {
        logic [7:0] ch;
        logic       char_valid;
        logic       end_of_query;
        logic [2:0] status;
    } t_result;

    function automatic t_result make_char(input logic [7:0] ch);
        t_result r;
        r.ch           = ch;
        r.char_valid   = 1'b1;
        r.end_of_query = 1'b0;
        r.status       = ST_OK;
        return r;
    endfunction

endpackage

[rtl/core/query_text_normalizer.sv]
// Query text normalizer: whitespace, quote and operator spacing with end-of-query status
//
// Takes one character per transfer and emits zero to three normalized characters,
// followed on the last character by a status result. All work for a character is
// done combinationally and written into a four-entry result buffer that drains one
// result per cycle while i_ready is high. The block takes one character per cycle
// while each character yields at most one result and i_ready is high; a character
// that yields k results (k up to 4) holds off the next character while the result
// buffer drains. Register 0 at byte address 0 sets max_length (reset 4096).
`include "query_text_normalizer_defines.svh"

module query_text_normalizer #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic [7:0]  i_next_ch,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_ch,
    output logic        o_char_valid,
    output logic        o_end_of_query,
    output logic [2:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WB    = LENGTH_BITS + 1;
    localparam int CMP_W = (WB > 16) ? WB : 16;
    localparam logic [LENGTH_BITS-1:0] IN_FULL = {LENGTH_BITS{1'b1}};
    localparam logic [WB-1:0]          OUT_SAT = {WB{1'b1}};

    logic [15:0]            r_max_len;
    logic [7:0]             r_prior;
    logic                   r_in_quotes;
    logic                   r_parity;
    logic [WB-1:0]          r_paren;
    logic [LENGTH_BITS-1:0] r_in_cnt;
    logic [WB-1:0]          r_out_cnt;
    logic [2:0]             r_err;
    qtn_pkg::t_result       r_buf [4];
    logic [2:0]             r_cnt;
    logic [1:0]             r_idx;

    logic [7:0]             n_prior;
    logic                   n_in_quotes;
    logic                   n_parity;
    logic [WB-1:0]          n_paren;
    logic [LENGTH_BITS-1:0] n_in_cnt;
    logic [WB-1:0]          n_out_cnt;
    logic [2:0]             n_err;
    qtn_pkg::t_result       n_buf [4];
    logic [2:0]             n_cnt;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   cfg_wr;
    logic                   in_full;
    logic                   out_over;
    logic [7:0]             c_conv;
    logic                   is_noise;
    logic                   put_pre;
    logic                   put_main;
    logic                   put_post;
    logic [2:0]             st;
    logic [WB:0]            out_sum;
    qtn_pkg::t_result       cur;
    qtn_pkg::t_result       st_item;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign o_ready  = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_ready);

    assign cur            = r_buf[r_idx];
    assign o_valid        = (r_cnt != 3'd0);
    assign o_out_ch       = cur.ch;
    assign o_char_valid   = cur.char_valid;
    assign o_end_of_query = cur.end_of_query;
    assign o_status       = cur.status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == qtn_pkg::REG_MAX_LENGTH) ? {16'd0, r_max_len} : 32'd0;

    assign in_full  = (CMP_W'(r_in_cnt) >= CMP_W'(r_max_len)) || (r_in_cnt == IN_FULL);
    assign out_over = CMP_W'(r_out_cnt) > CMP_W'(r_max_len);
    assign is_noise = (i_ch == qtn_pkg::CH_NUL) ||
                      ((i_ch >= qtn_pkg::CH_TAB) && (i_ch <= qtn_pkg::CH_CR));

    always_comb begin
        n_in_quotes = r_in_quotes ^ (i_ch == qtn_pkg::CH_QUOTE);
        n_parity    = r_parity ^ (i_ch == qtn_pkg::CH_QUOTE);
        n_err       = in_full ? qtn_pkg::ST_IN_LONG : r_err;
        if (out_over && (n_err == qtn_pkg::ST_OK)) begin
            n_err = qtn_pkg::ST_OUT_LONG;
        end
        n_in_cnt = in_full ? r_in_cnt : r_in_cnt + LENGTH_BITS'(1);
        c_conv   = (!n_in_quotes && is_noise) ? qtn_pkg::CH_SPACE : i_ch;
        n_prior  = c_conv;
        n_paren  = r_paren;
        put_pre  = 1'b0;
        put_main = 1'b1;
        put_post = 1'b0;
        if (!n_in_quotes) begin
            if (c_conv == qtn_pkg::CH_OPEN) begin
                n_paren = r_paren + WB'(1);
            end
            if (c_conv == qtn_pkg::CH_CLOSE) begin
                n_paren = r_paren - WB'(1);
            end
            if ((c_conv == qtn_pkg::CH_SPACE) && (r_prior == qtn_pkg::CH_SPACE)) begin
                put_main = 1'b0;
            end else if ((c_conv == qtn_pkg::CH_OPEN) || (c_conv == qtn_pkg::CH_CLOSE)) begin
                put_pre  = (r_prior != qtn_pkg::CH_SPACE);
                put_post = (i_next_ch != qtn_pkg::CH_SPACE);
            end else if ((c_conv == qtn_pkg::CH_LT) || (c_conv == qtn_pkg::CH_GT)) begin
                put_pre  = (r_prior != qtn_pkg::CH_SPACE) && (r_prior != qtn_pkg::CH_LT);
                put_post = (i_next_ch != qtn_pkg::CH_SPACE) &&
                           (i_next_ch != qtn_pkg::CH_EQ) && (i_next_ch != qtn_pkg::CH_GT);
            end else if (c_conv == qtn_pkg::CH_EQ) begin
                put_pre  = (r_prior != qtn_pkg::CH_SPACE) && (r_prior != qtn_pkg::CH_GT) &&
                           (r_prior != qtn_pkg::CH_LT);
                put_post = (i_next_ch != qtn_pkg::CH_SPACE);
            end
        end

        if (n_err != qtn_pkg::ST_OK) begin
            st = n_err;
        end else if (n_parity) begin
            st = qtn_pkg::ST_ODD_QUOTE;
        end else if (n_paren != '0) begin
            st = qtn_pkg::ST_PAREN;
        end else begin
            st = qtn_pkg::ST_OK;
        end
        st_item.ch           = 8'd0;
        st_item.char_valid   = 1'b0;
        st_item.end_of_query = 1'b1;
        st_item.status       = st;

        for (int k = 0; k < 4; k++) begin
            n_buf[k] = st_item;
        end
        n_cnt = 3'd0;
        if (put_pre) begin
            n_buf[n_cnt[1:0]] = qtn_pkg::make_char(qtn_pkg::CH_SPACE);
            n_cnt = n_cnt + 3'd1;
        end
        if (put_main) begin
            n_buf[n_cnt[1:0]] = qtn_pkg::make_char(c_conv);
            n_cnt = n_cnt + 3'd1;
        end
        if (put_post) begin
            n_buf[n_cnt[1:0]] = qtn_pkg::make_char(qtn_pkg::CH_SPACE);
            n_cnt = n_cnt + 3'd1;
        end

        out_sum   = {1'b0, r_out_cnt} + (WB + 1)'(n_cnt);
        n_out_cnt = out_sum[WB] ? OUT_SAT : out_sum[WB-1:0];

        if (i_is_last) begin
            n_buf[n_cnt[1:0]] = st_item;
            n_cnt       = n_cnt + 3'd1;
            n_prior     = qtn_pkg::CH_SPACE;
            n_in_quotes = 1'b0;
            n_parity    = 1'b0;
            n_paren     = '0;
            n_in_cnt    = '0;
            n_out_cnt   = '0;
            n_err       = qtn_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= qtn_pkg::MAX_LENGTH_RESET;
            r_prior     <= qtn_pkg::CH_SPACE;
            r_in_quotes <= 1'b0;
            r_parity    <= 1'b0;
            r_paren     <= '0;
            r_in_cnt    <= '0;
            r_out_cnt   <= '0;
            r_err       <= qtn_pkg::ST_OK;
            r_cnt       <= 3'd0;
            r_idx       <= 2'd0;
        end else begin
            if (cfg_wr && (paddr[2] == qtn_pkg::REG_MAX_LENGTH)) begin
                r_max_len <= pwdata[15:0];
            end
            if (in_xfer) begin
                r_prior     <= n_prior;
                r_in_quotes <= n_in_quotes;
                r_parity    <= n_parity;
                r_paren     <= n_paren;
                r_in_cnt    <= n_in_cnt;
                r_out_cnt   <= n_out_cnt;
                r_err       <= n_err;
                r_cnt       <= n_cnt;
                r_idx       <= 2'd0;
            end else if (out_xfer) begin
                r_cnt <= r_cnt - 3'd1;
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int k = 0; k < 4; k++) begin
                r_buf[k] <= n_buf[k];
            end
        end
    end

    `QTN_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, in_xfer && i_is_last, (r_in_cnt == '0) && (r_paren == '0) && (r_prior == qtn_pkg::CH_SPACE) && (r_err == qtn_pkg::ST_OK))
    `QTN_ASSERT_NEXT(a_last_gives_status, i_clk, i_rst_n, in_xfer && i_is_last, o_valid)
    `QTN_ASSERT_NOW(a_status_is_final, i_clk, i_rst_n, o_valid && o_end_of_query, r_cnt == 3'd1)
    `QTN_ASSERT_NOW(a_char_no_status, i_clk, i_rst_n, o_valid && o_char_valid, !o_end_of_query && (o_status == qtn_pkg::ST_OK))
    `QTN_ASSERT_NOW(a_buf_bound, i_clk, i_rst_n, 1'b1, (r_cnt <= 3'd4) && (32'(r_idx) + 32'(r_cnt) <= 32'd4))

endmodule
